@@ sv/dxsl_pkg.sv @@
// Package with shared types, constants and the expected-tag table of the subject locator.
package dxsl_pkg;

    localparam int MAX_CERT_BYTES = 65536;
    localparam int POS_LIMIT_INT  = (MAX_CERT_BYTES - 1 > 65535) ? 65535 : MAX_CERT_BYTES - 1;
    localparam logic [15:0] POS_LIMIT = POS_LIMIT_INT[15:0];

    localparam logic [7:0] TAG_SEQUENCE    = 8'h30;
    localparam logic [7:0] TAG_CONTEXT0    = 8'hA0;
    localparam logic [7:0] TAG_INTEGER     = 8'h02;
    localparam logic [7:0] LEN_LONG_FLAG   = 8'h80;
    localparam logic [7:0] LEN_COUNT_MASK  = 8'h7F;
    localparam logic [2:0] SUBJECT_INDEX   = 3'd7;
    localparam logic [2:0] ENTERED_HEADERS = 3'd2;

    typedef enum logic [1:0] {
        PH_TAG     = 2'd0,
        PH_LEN     = 2'd1,
        PH_LONGLEN = 2'd2,
        PH_SKIP    = 2'd3
    } parse_phase_t;

    typedef enum logic [1:0] {
        ST_FOUND  = 2'd0,
        ST_BADTAG = 2'd1,
        ST_SHORT  = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       first_byte;
        logic       last_byte;
    } beat_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] subject_offset;
        logic [31:0] subject_size;
    } result_t;

    function automatic logic [7:0] expected_tag(input logic [2:0] idx);
        logic [7:0] tag;
        case (idx)
            3'd0:    tag = TAG_SEQUENCE;
            3'd1:    tag = TAG_SEQUENCE;
            3'd2:    tag = TAG_CONTEXT0;
            3'd3:    tag = TAG_INTEGER;
            default: tag = TAG_SEQUENCE;
        endcase
        return tag;
    endfunction

endpackage

@@ sv/dxsl_parser.sv @@
// Header walker: parse state registers and the per-byte next-state and result logic.
module dxsl_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  dxsl_pkg::beat_t  beat,
    output logic             res_valid,
    output dxsl_pkg::result_t res
);

    dxsl_pkg::parse_phase_t phase_reg, phase_next;
    logic [2:0]  index_reg, index_next;
    logic [31:0] acc_reg, acc_next;
    logic [6:0]  lbl_reg, lbl_next;
    logic [31:0] skip_reg, skip_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] start_reg, start_next;
    logic [7:0]  hb_reg, hb_next;
    logic        given_reg, given_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dxsl_pkg::PH_TAG;
            index_reg <= '0;
            acc_reg   <= '0;
            lbl_reg   <= '0;
            skip_reg  <= '0;
            pos_reg   <= '0;
            start_reg <= '0;
            hb_reg    <= '0;
            given_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            index_reg <= index_next;
            acc_reg   <= acc_next;
            lbl_reg   <= lbl_next;
            skip_reg  <= skip_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            hb_reg    <= hb_next;
            given_reg <= given_next;
        end
    end

    always_comb
    begin
        logic        first;
        logic        last;
        logic [7:0]  b;
        logic        hdr_done;
        logic        found;
        logic        emit_bad;
        logic        emit_short;
        logic [32:0] size_sum;
        logic [6:0]  lbl_dec;

        b     = beat.byte_value;
        first = beat.first_byte;
        last  = beat.last_byte;

        phase_next = phase_reg;
        index_next = index_reg;
        acc_next   = acc_reg;
        lbl_next   = lbl_reg;
        skip_next  = skip_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        hb_next    = hb_reg;
        given_next = given_reg;

        hdr_done   = 1'b0;
        found      = 1'b0;
        emit_bad   = 1'b0;
        emit_short = 1'b0;
        size_sum   = '0;
        lbl_dec    = '0;
        res_valid  = 1'b0;
        res        = '0;

        if (step)
        begin
            // A first mark restarts the walk from the reset state.
            if (first)
            begin
                phase_next = dxsl_pkg::PH_TAG;
                index_next = '0;
                acc_next   = '0;
                lbl_next   = '0;
                skip_next  = '0;
                pos_next   = '0;
                start_next = '0;
                hb_next    = '0;
                given_next = 1'b0;
            end

            if (first || !given_reg)
            begin
                if (pos_next < dxsl_pkg::POS_LIMIT)
                begin
                    pos_next = pos_next + 16'd1;
                end

                case (phase_next)
                    dxsl_pkg::PH_TAG:
                    begin
                        if (last)
                        begin
                            emit_short = 1'b1;
                        end
                        else if (b != dxsl_pkg::expected_tag(index_next))
                        begin
                            emit_bad = 1'b1;
                        end
                        else
                        begin
                            start_next = first ? 16'd0 : pos_reg;
                            hb_next    = 8'd1;
                            phase_next = dxsl_pkg::PH_LEN;
                        end
                    end
                    dxsl_pkg::PH_LEN:
                    begin
                        hb_next = 8'd2;
                        if ((b & dxsl_pkg::LEN_LONG_FLAG) == 8'd0)
                        begin
                            acc_next = {24'd0, b};
                            hdr_done = 1'b1;
                        end
                        else
                        begin
                            acc_next = '0;
                            lbl_next = b[6:0];
                            if (b[6:0] == 7'd0)
                            begin
                                hdr_done = 1'b1;
                            end
                            else
                            begin
                                phase_next = dxsl_pkg::PH_LONGLEN;
                            end
                        end
                    end
                    dxsl_pkg::PH_LONGLEN:
                    begin
                        acc_next = {acc_next[23:0], b};
                        hb_next  = hb_next + 8'd1;
                        lbl_dec  = (lbl_next != 7'd0) ? lbl_next - 7'd1 : lbl_next;
                        lbl_next = lbl_dec;
                        if (lbl_dec == 7'd0)
                        begin
                            hdr_done = 1'b1;
                        end
                    end
                    dxsl_pkg::PH_SKIP:
                    begin
                        if (skip_next != 32'd0)
                        begin
                            skip_next = skip_next - 32'd1;
                        end
                        if (skip_next == 32'd0)
                        begin
                            phase_next = dxsl_pkg::PH_TAG;
                        end
                    end
                    default:
                    begin
                        phase_next = dxsl_pkg::PH_TAG;
                    end
                endcase

                if (hdr_done)
                begin
                    if (index_next >= dxsl_pkg::SUBJECT_INDEX)
                    begin
                        found = 1'b1;
                    end
                    else
                    begin
                        // Outer headers are entered; inner ones with content are skipped.
                        if (index_next < dxsl_pkg::ENTERED_HEADERS || acc_next == 32'd0)
                        begin
                            phase_next = dxsl_pkg::PH_TAG;
                        end
                        else
                        begin
                            skip_next  = acc_next;
                            phase_next = dxsl_pkg::PH_SKIP;
                        end
                        index_next = index_next + 3'd1;
                    end
                end

                size_sum = {25'd0, hb_next} + {1'b0, acc_next};

                if (emit_short)
                begin
                    res_valid  = 1'b1;
                    res.status = dxsl_pkg::ST_SHORT;
                end
                else if (emit_bad)
                begin
                    res_valid  = 1'b1;
                    res.status = dxsl_pkg::ST_BADTAG;
                end
                else if (found)
                begin
                    res_valid          = 1'b1;
                    res.status         = dxsl_pkg::ST_FOUND;
                    res.subject_offset = start_next;
                    res.subject_size   = size_sum[32] ? 32'hFFFF_FFFF : size_sum[31:0];
                end
                else if (last)
                begin
                    res_valid  = 1'b1;
                    res.status = dxsl_pkg::ST_SHORT;
                end

                if (res_valid)
                begin
                    given_next = 1'b1;
                end
            end
        end
    end

endmodule

@@ sv/der_x509_subject_locator.sv @@
// Top level of the DER certificate subject locator: input register, parser and result register.
//
// The byte channel (byte_valid, byte_stall, byte_data) carries one certificate byte a beat,
// with first and last marks; a beat is taken at a clock edge with byte_valid high and
// byte_stall low. The result channel (result_valid, result_stall, result_data) gives at
// most one result per certificate: the subject offset and size, a tag mismatch, or early
// end of data. Bytes after a result are ignored until the next first mark.
// An accepted byte passes through the input register, then through the header walker
// into the result register. Throughput is one byte per cycle unless the receiver stalls;
// the walker updates its counters as each byte is taken.
// When the receiver stalls, a waiting result holds; the block takes at most one more byte
// into its input register, then raises byte_stall until the result is taken.
// Reset clears both registers' valid flags and puts the walker at the start of a
// certificate, so bytes sent before any first mark are parsed as a certificate.
module der_x509_subject_locator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  dxsl_pkg::beat_t    byte_data,
    output logic               result_valid,
    input  logic               result_stall,
    output dxsl_pkg::result_t  result_data
);

    logic              in_valid_reg;
    dxsl_pkg::beat_t   in_beat_reg;
    logic              out_valid_reg;
    dxsl_pkg::result_t out_data_reg;
    logic              advance;
    logic              step;
    logic              res_valid;
    dxsl_pkg::result_t res;

    // The held byte moves on whenever the result register is free or being emptied.
    assign advance    = !out_valid_reg || !result_stall;
    assign byte_stall = in_valid_reg && !advance;
    assign step       = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!byte_stall)
            begin
                in_valid_reg <= byte_valid;
            end
            if (advance)
            begin
                out_valid_reg <= step && res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            in_beat_reg <= byte_data;
        end
        if (step && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    dxsl_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .beat      (in_beat_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

endmodule
